/* sv/assert_macros.svh */
// assertion macros used by the top level of the segment filter
// no dependencies; synthesis builds see empty bodies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SSIF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SSIF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SSIF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSIF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/ssif_pkg.sv */
// types, codes and helpers of the segment set intersection filter
// no dependencies; used by the cell, the tester and the top level

`default_nettype none

package ssif_pkg;

   localparam int COORD_BITS       = 12;
   localparam int DIFF_BITS        = COORD_BITS + 1;
   localparam int PROD_BITS        = 2 * DIFF_BITS;
   localparam int MAX_SEGMENTS_DEF = 256;
   localparam int COUNT_OUT_BITS   = 9;
   localparam int TURNS            = 4;

   typedef enum logic [1:0] {
      OP_OFFER = 2'd0,
      OP_FORCE = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic                      crosses;
      logic                      degenerate;
      logic                      table_full;
      logic [COUNT_OUT_BITS-1:0] stored_count;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by;
   } seg_type;

   // the four differences of one orientation test of p, q, r
   typedef struct packed {
      logic signed [DIFF_BITS-1:0] ry_py;
      logic signed [DIFF_BITS-1:0] qx_px;
      logic signed [DIFF_BITS-1:0] qy_py;
      logic signed [DIFF_BITS-1:0] rx_px;
   } turn_diff_type;

   // tester status toward the sequencer
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit_cross;
   } tst_out_type;

   function automatic logic signed [DIFF_BITS-1:0] coord_diff(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b
   );
      logic signed [DIFF_BITS-1:0] d;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      return d;
   endfunction

   function automatic turn_diff_type turn_diffs(
      input logic [COORD_BITS-1:0] px,
      input logic [COORD_BITS-1:0] py,
      input logic [COORD_BITS-1:0] qx,
      input logic [COORD_BITS-1:0] qy,
      input logic [COORD_BITS-1:0] rx,
      input logic [COORD_BITS-1:0] ry
   );
      turn_diff_type t;
      t.ry_py = coord_diff(ry, py);
      t.qx_px = coord_diff(qx, px);
      t.qy_py = coord_diff(qy, py);
      t.rx_px = coord_diff(rx, px);
      return t;
   endfunction

endpackage

`default_nettype wire

/* sv/ssif_cell.sv */
// one cell of the segment ring: holds one stored segment
// depends on ssif_pkg for the segment type

`default_nettype none

module ssif_cell
   import ssif_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    shift_en,
   input  wire seg_type seg_prev,
   output seg_type      seg_out
);

   seg_type seg_ff;
   seg_type seg_in;

   // take the neighbor's segment on a shift, hold otherwise
   always_comb begin
      seg_in = shift_en ? seg_prev : seg_ff;
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg_out = seg_ff;

endmodule

`default_nettype wire

/* sv/ssif_tester.sv */
// three-stage pipelined strict ccw crossing test of two segments
// depends on ssif_pkg for segment, difference and status types

`default_nettype none

module ssif_tester
   import ssif_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire seg_type seg_s,
   input  wire seg_type seg_t,
   output tst_out_type  status
);

   turn_diff_type               diff_in  [TURNS];
   turn_diff_type               diff_ff  [TURNS];
   logic signed [PROD_BITS-1:0] lhs_in   [TURNS];
   logic signed [PROD_BITS-1:0] rhs_in   [TURNS];
   logic signed [PROD_BITS-1:0] lhs_ff   [TURNS];
   logic signed [PROD_BITS-1:0] rhs_ff   [TURNS];
   logic [TURNS-1:0]            left_turn;
   logic                        cross_in;
   logic                        cross_ff;
   logic                        v1_ff;
   logic                        v2_ff;
   logic                        v3_ff;

   // stage 1: differences of the four orientation tests
   always_comb begin
      diff_in[0] = turn_diffs(seg_s.ax, seg_s.ay, seg_t.ax, seg_t.ay, seg_t.bx, seg_t.by);
      diff_in[1] = turn_diffs(seg_s.bx, seg_s.by, seg_t.ax, seg_t.ay, seg_t.bx, seg_t.by);
      diff_in[2] = turn_diffs(seg_s.ax, seg_s.ay, seg_s.bx, seg_s.by, seg_t.ax, seg_t.ay);
      diff_in[3] = turn_diffs(seg_s.ax, seg_s.ay, seg_s.bx, seg_s.by, seg_t.bx, seg_t.by);
   end

   // stage 2: cross products, one multiplier per term
   always_comb begin
      for (int i = 0; i < TURNS; i++) begin
         lhs_in[i] = diff_ff[i].ry_py * diff_ff[i].qx_px;
         rhs_in[i] = diff_ff[i].qy_py * diff_ff[i].rx_px;
      end
   end

   // stage 3: strict left turns and the crossing rule
   always_comb begin
      for (int i = 0; i < TURNS; i++) begin
         left_turn[i] = lhs_ff[i] > rhs_ff[i];
      end
      cross_in = (left_turn[0] ^ left_turn[1]) & (left_turn[2] ^ left_turn[3]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TURNS; i++) begin
         diff_ff[i] <= diff_in[i];
         lhs_ff[i]  <= lhs_in[i];
         rhs_ff[i]  <= rhs_in[i];
      end
      cross_ff <= cross_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      status.busy      = v1_ff | v2_ff | v3_ff;
      status.hit_valid = v3_ff;
      status.hit_cross = cross_ff;
   end

endmodule

`default_nettype wire

/* sv/segment_set_intersection_filter_top.sv */
// top level of the segment set intersection filter: sequencer, segment ring, result register
// depends on ssif_pkg, ssif_cell, ssif_tester and assert_macros.svh

// Keeps up to MAX_SEGMENTS line segments in a ring of cells, newest in the
// first cell. An offer (op 0) with equal endpoints comes back degenerate at
// once; otherwise, against a non-empty table, the ring turns one full
// revolution, one cell a cycle, and the cell at the end of the ring feeds a
// single three-stage ccw tester that compares it with the offered segment;
// only cells that hold stored segments count. A segment that crosses none is
// stored when there is room, else table_full is reported. A forced insert
// (op 1) stores without a test, a clear (op 2) empties the table, op 3 only
// reports the count. Every item gives one result item. An offer against a
// non-empty table has its result after one revolution of the ring and the
// drain of the tester pipeline; every other item goes straight to the
// result. One item is worked on at a time; the next is taken while the
// previous result still waits in the output register. The store needs no
// clearing after reset: only the count is reset.

`default_nettype none

module segment_set_intersection_filter_top
   import ssif_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

`include "assert_macros.svh"

   // count holds 0..MAX_SEGMENTS, step walks one revolution of the ring
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   state_type      state_ff;
   state_type      state_in;
   req_type        item_ff;
   req_type        item_in;
   logic           deg_ff;
   logic           deg_in;
   logic           cross_ff;
   logic           cross_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [SW-1:0]  step_ff;
   logic [SW-1:0]  step_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;

   // sequencer outputs
   logic           req_fire;
   logic           finish_fire;
   logic           ring_rotate;
   logic           ring_insert;
   logic           ring_shift;
   logic           tap_valid;
   logic           last_step;
   logic           out_free;

   // result decision
   logic           room;
   logic           do_store;
   logic           do_clear;
   rsp_type        result;
   logic [CW+COUNT_OUT_BITS-1:0] count_wide;

   seg_type        item_seg;
   seg_type        ring_head;
   seg_type        cell_q [MAX_SEGMENTS];
   tst_out_type    tst;

   // ---------------------------------------------------------------------
   // segment ring: cell 0 takes the new segment on an insert and the tail
   // segment on a rotation, so a full revolution restores the order
   // ---------------------------------------------------------------------
   always_comb begin
      item_seg.ax = item_ff.start_x;
      item_seg.ay = item_ff.start_y;
      item_seg.bx = item_ff.end_x;
      item_seg.by = item_ff.end_y;
      ring_head   = ring_insert ? item_seg : cell_q[MAX_SEGMENTS-1];
      ring_shift  = ring_rotate | ring_insert;
   end

   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_ring
      if (g == 0) begin : g_head
         ssif_cell u_cell (
            .clock    (clock),
            .shift_en (ring_shift),
            .seg_prev (ring_head),
            .seg_out  (cell_q[g])
         );
      end else begin : g_body
         ssif_cell u_cell (
            .clock    (clock),
            .shift_en (ring_shift),
            .seg_prev (cell_q[g-1]),
            .seg_out  (cell_q[g])
         );
      end
   end

   // at step k the tail holds cell MAX_SEGMENTS-1-k, stored when k >= MAX - count
   always_comb begin
      tap_valid = ((CW+1)'(step_ff) + (CW+1)'(count_ff)) >= (CW+1)'(MAX_SEGMENTS);
      last_step = step_ff == SW'(MAX_SEGMENTS - 1);
   end

   ssif_tester u_tester (
      .clock    (clock),
      .reset    (reset),
      .in_valid (ring_rotate & tap_valid),
      .seg_s    (item_seg),
      .seg_t    (cell_q[MAX_SEGMENTS-1]),
      .status   (tst)
   );

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ((req_data.op == OP_OFFER) && !deg_in && (count_ff != '0)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (last_step) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!tst.busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      req_stall   = 1'b1;
      ring_rotate = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_SCAN: begin
            ring_rotate = 1'b1;
         end
         S_DRAIN: begin
            ring_rotate = 1'b0;
         end
         S_FINISH: begin
            finish_fire = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      req_fire    = req_valid && !req_stall;
      ring_insert = finish_fire && do_store;
   end

   // ---------------------------------------------------------------------
   // result decision, taken in the finish state once any scan has drained
   // ---------------------------------------------------------------------
   always_comb begin
      room     = count_ff < CW'(MAX_SEGMENTS);
      do_store = 1'b0;
      do_clear = 1'b0;
      result   = '0;
      case (item_ff.op)
         OP_OFFER: begin
            if (deg_ff) begin
               result.degenerate = 1'b1;
            end else if (cross_ff) begin
               result.crosses = 1'b1;
            end else if (room) begin
               result.accepted = 1'b1;
               do_store        = 1'b1;
            end else begin
               result.table_full = 1'b1;
            end
         end
         OP_FORCE: begin
            if (room) begin
               result.accepted = 1'b1;
               do_store        = 1'b1;
            end else begin
               result.table_full = 1'b1;
            end
         end
         OP_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            do_store = 1'b0;
         end
      endcase

      if (do_clear) begin
         count_in = '0;
      end else if (do_store) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
      // stored_count shows the low bits of the count
      count_wide          = {{COUNT_OUT_BITS{1'b0}}, count_in};
      result.stored_count = count_wide[COUNT_OUT_BITS-1:0];
   end

   // ---------------------------------------------------------------------
   // item registers and output register
   // ---------------------------------------------------------------------
   always_comb begin
      item_in  = req_fire ? req_data : item_ff;
      deg_in   = (req_data.start_x == req_data.end_x) && (req_data.start_y == req_data.end_y);
      step_in  = req_fire ? '0 : (ring_rotate ? step_ff + SW'(1) : step_ff);
      cross_in = req_fire ? 1'b0 : (cross_ff | (tst.hit_valid & tst.hit_cross));
      rsp_in   = finish_fire ? result : rsp_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      cross_ff <= cross_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
      if (req_fire) begin
         deg_ff <= deg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_fire) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `SSIF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_SEGMENTS))
   `SSIF_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   `SSIF_ASSERT_NXT(a_count_held_in_scan, clock, reset, state_ff == S_SCAN, $stable(count_ff))
   `SSIF_ASSERT_IMP(a_tester_empty_at_finish, clock, reset, state_ff == S_FINISH, !tst.busy)
   `SSIF_ASSERT_IMP(a_accept_is_clean, clock, reset, rsp_valid_ff && rsp_ff.accepted,
                    !rsp_ff.crosses && !rsp_ff.degenerate && !rsp_ff.table_full)

endmodule

`default_nettype wire

/* test/segment_set_intersection_filter_top_tb.sv */
// testbench of the segment set intersection filter: directed, full-table, backpressure and random
// tests checked item by item against a behavioral model of the segment table; needs ssif_pkg
`timescale 1ns / 1ps

`default_nettype none

module segment_set_intersection_filter_top_tb;
   import ssif_pkg::*;

   localparam int TABLE_DEPTH    = MAX_SEGMENTS_DEF;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   // op code 3 has no operation behind it; the block only reports the count
   localparam logic [1:0] OP_RESERVED = 2'd3;
   // cycles with nothing accepted on either side before the run is given up
   localparam int WATCHDOG_LIMIT = 5000;
   // long receiver hold-off, well past one full ring revolution
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 700;

   typedef enum int {
      RX_FLOW,
      RX_LIGHT,
      RX_HEAVY
   } rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // model of the segment table, updated when an item is accepted
   seg_type     table_segs [TABLE_DEPTH];
   int          table_count = 0;
   rsp_type     expected_results [$];
   int          error_count = 0;

   // sender burst shaping
   int          burst_left = 0;
   // receiver stall pattern and the long hold-off
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          mode_left = 0;
   rx_mode_type rx_mode = RX_FLOW;
   int          quiet_cycles = 0;

   segment_set_intersection_filter_top #(
      .MAX_SEGMENTS(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // table model
   // ---------------------------------------------------------------

   // strict counter-clockwise turn of p, q, r, exact in 64 bits
   function automatic bit is_left_turn(input longint px, input longint py,
                                       input longint qx, input longint qy,
                                       input longint rx, input longint ry);
      return (ry - py) * (qx - px) > (qy - py) * (rx - px);
   endfunction

   // offered segment s against stored segment t, orientation order matters
   function automatic bit segments_cross(input seg_type s, input seg_type t);
      bit o1, o2, o3, o4;
      o1 = is_left_turn(s.ax, s.ay, t.ax, t.ay, t.bx, t.by);
      o2 = is_left_turn(s.bx, s.by, t.ax, t.ay, t.bx, t.by);
      o3 = is_left_turn(s.ax, s.ay, s.bx, s.by, t.ax, t.ay);
      o4 = is_left_turn(s.ax, s.ay, s.bx, s.by, t.bx, t.by);
      return (o1 != o2) && (o3 != o4);
   endfunction

   // applies one item to the table model and returns the result it must give
   function automatic rsp_type predict_filter_result(input req_type item);
      rsp_type result;
      seg_type seg;
      bit      hit;
      int      i;
      result = '0;
      seg.ax = item.start_x;
      seg.ay = item.start_y;
      seg.bx = item.end_x;
      seg.by = item.end_y;
      case (item.op)
         OP_OFFER: begin
            if (seg.ax == seg.bx && seg.ay == seg.by) begin
               result.degenerate = 1'b1;
            end else begin
               hit = 1'b0;
               // only the entries that hold stored segments take part
               for (i = 0; i < table_count; i++) begin
                  if (segments_cross(seg, table_segs[i]))
                     hit = 1'b1;
               end
               if (hit) begin
                  result.crosses = 1'b1;
               end else if (table_count < TABLE_DEPTH) begin
                  table_segs[table_count] = seg;
                  table_count++;
                  result.accepted = 1'b1;
               end else begin
                  result.table_full = 1'b1;
               end
            end
         end
         OP_FORCE: begin
            // no degeneracy or crossing test on a forced store
            if (table_count < TABLE_DEPTH) begin
               table_segs[table_count] = seg;
               table_count++;
               result.accepted = 1'b1;
            end else begin
               result.table_full = 1'b1;
            end
         end
         OP_CLEAR: begin
            table_count = 0;
         end
         default: begin
            // reserved op: state untouched, count reported
         end
      endcase
      result.stored_count = table_count[COUNT_OUT_BITS-1:0];
      return result;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input int sx, input int sy,
                                        input int ex, input int ey);
      req_type item;
      item.op      = op;
      item.start_x = sx[COORD_BITS-1:0];
      item.start_y = sy[COORD_BITS-1:0];
      item.end_x   = ex[COORD_BITS-1:0];
      item.end_y   = ey[COORD_BITS-1:0];
      return item;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // ---------------------------------------------------------------
   // sender: one item per call, bursts with random gaps between them
   // ---------------------------------------------------------------
   task automatic send_item(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      // accepted at the first edge that sees stall low
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_filter_result(item));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         // about a quarter of the bursts follow back to back
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            // valid only drops when the next raise is in a later step
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // receiver: stall pattern of its own, plus a long hold-off on request
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (mode_left == 0) begin
         mode_left = $urandom_range(20, 300);
         case ($urandom_range(0, 2))
            0:       rx_mode = RX_FLOW;
            1:       rx_mode = RX_LIGHT;
            default: rx_mode = RX_HEAVY;
         endcase
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FLOW:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:  rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // result checking, in order against the oldest expectation
   // ---------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("accepted", want.accepted, rsp_data.accepted);
            check_field("crosses", want.crosses, rsp_data.crosses);
            check_field("degenerate", want.degenerate, rsp_data.degenerate);
            check_field("table_full", want.table_full, rsp_data.table_full);
            check_field("stored_count", want.stored_count, rsp_data.stored_count);
         end
      end
   end

   // watchdog: a long run of cycles with no handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // extremes of the fields, every op, and the corner cases of the crossing test
   task automatic test_directed_cases();
      send_item(make_req(OP_RESERVED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      // degenerate offers at both corners of the coordinate range
      send_item(make_req(OP_OFFER, 0, 0, 0, 0));
      send_item(make_req(OP_OFFER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      // first offer into an empty table, full diagonal
      send_item(make_req(OP_OFFER, 0, 0, COORD_MAX, COORD_MAX));
      // the other diagonal crosses it
      send_item(make_req(OP_OFFER, 0, COORD_MAX, COORD_MAX, 0));
      // shares an endpoint only
      send_item(make_req(OP_OFFER, COORD_MAX, COORD_MAX, COORD_MAX, 0));
      // collinear and overlapping
      send_item(make_req(OP_OFFER, 100, 100, 200, 200));
      // parallel, one unit off
      send_item(make_req(OP_OFFER, 1, 0, COORD_MAX, COORD_MAX - 1));
      // endpoint lying on a stored segment
      send_item(make_req(OP_OFFER, 2048, 2048, 2048, COORD_MAX));
      // forced stores skip both tests
      send_item(make_req(OP_FORCE, 0, COORD_MAX, COORD_MAX, 0));
      send_item(make_req(OP_FORCE, 5, 5, 5, 5));
      send_item(make_req(OP_OFFER, 0, 1000, COORD_MAX, 1000));
      send_item(make_req(OP_CLEAR, COORD_MAX, 0, COORD_MAX, 0));
      // same crossing segment is clear after the table is emptied
      send_item(make_req(OP_OFFER, 0, COORD_MAX, COORD_MAX, 0));
      send_item(make_req(OP_RESERVED, 0, 0, 0, 0));
      send_item(make_req(OP_CLEAR, 0, 0, 0, 0));
   endtask

   // fill the table with forced stores, then hit every refusal on a full table
   task automatic test_full_table();
      int n, sx, sy;
      send_item(make_req(OP_CLEAR, 0, 0, 0, 0));
      // a wide bar first so a vertical offer is sure to cross something
      send_item(make_req(OP_FORCE, 0, 100, COORD_MAX, 100));
      for (n = 1; n < TABLE_DEPTH; n++) begin
         // short segments in the lower half, leaving the top row free
         sx = $urandom_range(0, COORD_MAX);
         sy = $urandom_range(0, 2047);
         send_item(make_req(OP_FORCE, sx, sy, clamp_coord(sx + $urandom_range(0, 40) - 20),
                            clamp_coord(sy + $urandom_range(0, 40) - 20)));
      end
      send_item(make_req(OP_FORCE, 10, 10, 20, 20));
      // clear of everything stored but no room
      send_item(make_req(OP_OFFER, 0, COORD_MAX, 1, COORD_MAX));
      // a crossing offer reports crosses, not table_full
      send_item(make_req(OP_OFFER, 2000, 0, 2000, COORD_MAX));
      send_item(make_req(OP_OFFER, 7, 7, 7, 7));
      send_item(make_req(OP_RESERVED, 1, 2, 3, 4));
      send_item(make_req(OP_CLEAR, 0, 0, 0, 0));
   endtask

   // receiver holds off for a long stretch while the sender keeps sending items
   task automatic test_output_backpressure();
      int n;
      hold_request = 1'b1;
      for (n = 0; n < 12; n++) begin
         if (n == 4)
            send_item(make_req(OP_OFFER, 300, 300, 400, 350));
         else if (n % 2 == 0)
            send_item(make_req(OP_FORCE, 10 * n, 3000, 10 * n + 5, 3010));
         else
            send_item(make_req(OP_RESERVED, n, n, n, n));
      end
   endtask

   // mostly well-formed offers with random content, mixed with forced stores,
   // clears, degenerate offers and the reserved op
   task automatic test_random_traffic(input int count);
      int      n, pick, sx, sy, ex, ey, k;
      seg_type old_seg;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         sx   = $urandom_range(0, COORD_MAX);
         sy   = $urandom_range(0, COORD_MAX);
         ex   = clamp_coord(sx + $urandom_range(0, 96) - 48);
         ey   = clamp_coord(sy + $urandom_range(0, 96) - 48);
         if (pick < 2) begin
            send_item(make_req(OP_CLEAR, sx, sy, ex, ey));
         end else if (pick < 4) begin
            send_item(make_req(OP_RESERVED, sx, sy, $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX)));
         end else if (pick < 12) begin
            send_item(make_req(OP_FORCE, sx, sy, ex, ey));
         end else if (pick < 17) begin
            send_item(make_req(OP_OFFER, sx, sy, sx, sy));
         end else if (pick < 30) begin
            // long random segment, likely to cross once the table fills
            send_item(make_req(OP_OFFER, sx, sy, $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX)));
         end else if (pick < 45 && table_count > 0) begin
            // built from a stored segment: shared endpoint, collinear, reversed copy
            old_seg = table_segs[$urandom_range(0, table_count - 1)];
            k = $urandom_range(0, 2);
            if (k == 0)
               send_item(make_req(OP_OFFER, old_seg.bx, old_seg.by, ex, ey));
            else if (k == 1)
               send_item(make_req(OP_OFFER, old_seg.ax, old_seg.ay,
                  clamp_coord(2 * int'(old_seg.bx) - int'(old_seg.ax)),
                  clamp_coord(2 * int'(old_seg.by) - int'(old_seg.ay))));
            else
               send_item(make_req(OP_OFFER, old_seg.bx, old_seg.by, old_seg.ax, old_seg.ay));
         end else begin
            // short segment, mostly stored until the table gets crowded
            send_item(make_req(OP_OFFER, sx, sy, ex, ey));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_table();
      test_output_backpressure();
      test_random_traffic(RANDOM_ITEMS);
      @(posedge clock);
      req_valid <= 1'b0;
      // drain; the watchdog covers a result that never comes
      while (expected_results.size() != 0) @(posedge clock);
      // keep running to catch stray results
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/ssif_pkg.sv
sv/ssif_cell.sv
sv/ssif_tester.sv
sv/segment_set_intersection_filter_top.sv
test/segment_set_intersection_filter_top_tb.sv
